FILE: rtl/anbs_pkg.sv
package anbs_pkg;

    localparam int DATA_W  = 8;
    localparam int LEN_W   = 7;
    localparam int INDEX_W = 6;
    localparam int TYPE_W  = 5;
    localparam int BANKS   = 3;

    localparam logic MODE_STREAM = 1'b0;
    localparam logic MODE_READ   = 1'b1;

    localparam logic [TYPE_W-1:0] NAL_SLICE = 5'd1;
    localparam logic [TYPE_W-1:0] NAL_IDR   = 5'd5;
    localparam logic [TYPE_W-1:0] NAL_SPS   = 5'd7;
    localparam logic [TYPE_W-1:0] NAL_PPS   = 5'd8;

    localparam int MIN_SET_LEN = 4;

    typedef logic [1:0] bank_t;

    localparam bank_t BANK_A = 2'd0;
    localparam bank_t BANK_B = 2'd1;
    localparam bank_t BANK_C = 2'd2;

    typedef struct packed {
        logic             is_summary;
        logic             keyframe_seen;
        logic             vcl_seen;
        logic [LEN_W-1:0] sps_length;
        logic [LEN_W-1:0] pps_length;
        logic             in_range;
        bank_t            bank;
    } res_t;

endpackage

FILE: rtl/anbs_ram.sv
module anbs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/anbs_scan.sv
module anbs_scan #(
    parameter int SET_BYTES = 64
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       accept,
    input  logic                       mode,
    input  logic [7:0]                 data_byte,
    input  logic                       last_byte,
    input  logic                       which_set,
    input  logic [5:0]                 read_index,
    output logic                       res_valid,
    output anbs_pkg::res_t             res,
    output logic [2:0]                 wr_en,
    output logic [$clog2(SET_BYTES)-1:0] wr_addr,
    output logic [7:0]                 wr_data,
    output logic [$clog2(SET_BYTES)-1:0] rd_addr
);

    import anbs_pkg::*;

    localparam int AW = $clog2(SET_BYTES);
    localparam int CW = $clog2(SET_BYTES + 2);
    localparam int XW = (CW > INDEX_W) ? CW : INDEX_W;

    localparam logic [CW-1:0] SET_C = CW'(SET_BYTES);
    localparam logic [CW-1:0] MIN_C = CW'(MIN_SET_LEN);
    localparam logic [CW-1:0] ONE_C = CW'(1);

    logic [1:0]        zero_run_reg, zero_run_next;
    logic              inside_nal_reg, inside_nal_next;
    logic              expect_header_reg, expect_header_next;
    logic [TYPE_W-1:0] current_type_reg, current_type_next;
    logic [CW-1:0]     byte_count_reg, byte_count_next;
    logic [CW-1:0]     kept_length_reg, kept_length_next;
    logic [CW-1:0]     sps_count_reg, sps_count_next;
    logic [CW-1:0]     pps_count_reg, pps_count_next;
    logic              key_flag_reg, key_flag_next;
    logic              slice_flag_reg, slice_flag_next;
    bank_t             stage_bank_reg, stage_bank_next;
    bank_t             sps_bank_reg, sps_bank_next;
    bank_t             pps_bank_reg, pps_bank_next;

    logic              commit_en;
    logic [CW-1:0]     commit_len;
    logic              stage_we;
    logic              sps_hit;
    logic              pps_hit;
    logic [XW-1:0]     index_x;
    logic [XW-1:0]     count_x;

    always_comb
    begin
        zero_run_next      = zero_run_reg;
        inside_nal_next    = inside_nal_reg;
        expect_header_next = expect_header_reg;
        current_type_next  = current_type_reg;
        byte_count_next    = byte_count_reg;
        kept_length_next   = kept_length_reg;
        sps_count_next     = sps_count_reg;
        pps_count_next     = pps_count_reg;
        key_flag_next      = key_flag_reg;
        slice_flag_next    = slice_flag_reg;
        stage_bank_next    = stage_bank_reg;
        sps_bank_next      = sps_bank_reg;
        pps_bank_next      = pps_bank_reg;
        commit_en          = 1'b0;
        commit_len         = byte_count_reg;
        stage_we           = 1'b0;
        wr_addr            = byte_count_reg[AW-1:0];
        wr_data            = data_byte;

        if (accept && mode == MODE_STREAM)
        begin
            if (expect_header_reg)
            begin
                current_type_next  = data_byte[TYPE_W-1:0];
                stage_we           = 1'b1;
                wr_addr            = '0;
                byte_count_next    = ONE_C;
                kept_length_next   = ONE_C;
                zero_run_next      = 2'd0;
                expect_header_next = 1'b0;
                inside_nal_next    = 1'b1;
                commit_en          = last_byte;
                commit_len         = ONE_C;
            end
            else if (data_byte == 8'd1 && zero_run_reg[1])
            begin
                commit_en          = inside_nal_reg;
                commit_len         = kept_length_reg;
                inside_nal_next    = 1'b0;
                expect_header_next = 1'b1;
                zero_run_next      = 2'd0;
            end
            else
            begin
                if (data_byte == 8'd0)
                begin
                    if (zero_run_reg != 2'd3)
                    begin
                        zero_run_next = zero_run_reg + 2'd1;
                    end
                end
                else
                begin
                    zero_run_next = 2'd0;
                end
                if (inside_nal_reg)
                begin
                    stage_we = (byte_count_reg < SET_C);
                    if (byte_count_reg <= SET_C)
                    begin
                        byte_count_next = byte_count_reg + ONE_C;
                    end
                    if (data_byte != 8'd0)
                    begin
                        kept_length_next = byte_count_next;
                    end
                    commit_en  = last_byte;
                    commit_len = byte_count_next;
                end
            end
        end

        sps_hit = commit_en && current_type_next == NAL_SPS
                  && commit_len >= MIN_C && commit_len <= SET_C;
        pps_hit = commit_en && current_type_next == NAL_PPS
                  && commit_len >= MIN_C && commit_len <= SET_C;

        if (sps_hit)
        begin
            sps_bank_next   = stage_bank_reg;
            stage_bank_next = sps_bank_reg;
            sps_count_next  = commit_len;
        end
        else if (pps_hit)
        begin
            pps_bank_next   = stage_bank_reg;
            stage_bank_next = pps_bank_reg;
            pps_count_next  = commit_len;
        end
        else if (commit_en && current_type_next == NAL_IDR)
        begin
            key_flag_next   = 1'b1;
            slice_flag_next = 1'b1;
        end
        else if (commit_en && current_type_next == NAL_SLICE)
        begin
            slice_flag_next = 1'b1;
        end

        index_x = XW'(read_index);
        count_x = (which_set == 1'b0) ? XW'(sps_count_reg) : XW'(pps_count_reg);

        res_valid         = accept && (mode == MODE_READ || last_byte);
        res.is_summary    = (mode == MODE_STREAM);
        res.keyframe_seen = (mode == MODE_STREAM) && key_flag_next;
        res.vcl_seen      = (mode == MODE_STREAM) && slice_flag_next;
        res.sps_length    = LEN_W'(sps_count_next);
        res.pps_length    = LEN_W'(pps_count_next);
        res.in_range      = (mode == MODE_READ) && (index_x < count_x)
                            && (index_x < XW'(SET_BYTES));
        res.bank          = (which_set == 1'b0) ? sps_bank_reg : pps_bank_reg;

        if (accept && mode == MODE_STREAM && last_byte)
        begin
            key_flag_next      = 1'b0;
            slice_flag_next    = 1'b0;
            zero_run_next      = 2'd0;
            inside_nal_next    = 1'b0;
            expect_header_next = 1'b0;
            current_type_next  = '0;
            byte_count_next    = '0;
            kept_length_next   = '0;
        end
    end

    assign rd_addr  = index_x[AW-1:0];
    assign wr_en[0] = stage_we && stage_bank_reg == BANK_A;
    assign wr_en[1] = stage_we && stage_bank_reg == BANK_B;
    assign wr_en[2] = stage_we && stage_bank_reg == BANK_C;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zero_run_reg      <= 2'd0;
            inside_nal_reg    <= 1'b0;
            expect_header_reg <= 1'b0;
            current_type_reg  <= '0;
            byte_count_reg    <= '0;
            kept_length_reg   <= '0;
            sps_count_reg     <= '0;
            pps_count_reg     <= '0;
            key_flag_reg      <= 1'b0;
            slice_flag_reg    <= 1'b0;
            stage_bank_reg    <= BANK_A;
            sps_bank_reg      <= BANK_B;
            pps_bank_reg      <= BANK_C;
        end
        else
        begin
            zero_run_reg      <= zero_run_next;
            inside_nal_reg    <= inside_nal_next;
            expect_header_reg <= expect_header_next;
            current_type_reg  <= current_type_next;
            byte_count_reg    <= byte_count_next;
            kept_length_reg   <= kept_length_next;
            sps_count_reg     <= sps_count_next;
            pps_count_reg     <= pps_count_next;
            key_flag_reg      <= key_flag_next;
            slice_flag_reg    <= slice_flag_next;
            stage_bank_reg    <= stage_bank_next;
            sps_bank_reg      <= sps_bank_next;
            pps_bank_reg      <= pps_bank_next;
        end
    end

    // The three banks must always be a permutation, or a commit would alias two sets.
    a_bank_perm: assert property (@(posedge clk) disable iff (!rst_n)
        stage_bank_reg != sps_bank_reg && stage_bank_reg != pps_bank_reg
        && sps_bank_reg != pps_bank_reg)
        else $error("bank mapping is not a permutation");

    a_kept_le_count: assert property (@(posedge clk) disable iff (!rst_n)
        kept_length_reg <= byte_count_reg)
        else $error("kept length exceeds byte count");

    a_header_excl: assert property (@(posedge clk) disable iff (!rst_n)
        expect_header_reg |-> !inside_nal_reg)
        else $error("header expected while inside a NAL");

endmodule

FILE: rtl/anbs_out.sv
module anbs_out (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_accept,
    input  logic                 res_valid,
    input  anbs_pkg::res_t       res,
    input  logic [2:0][7:0]      ram_q,
    output logic                 in_stall,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic                 is_summary,
    output logic                 keyframe_seen,
    output logic                 vcl_seen,
    output logic [6:0]           sps_length,
    output logic [6:0]           pps_length,
    output logic [7:0]           read_data
);

    import anbs_pkg::*;

    logic              p1_valid_reg;
    res_t              p1_reg;
    logic              out_valid_reg;
    logic              is_summary_reg;
    logic              keyframe_reg;
    logic              vcl_reg;
    logic [LEN_W-1:0]  sps_length_reg;
    logic [LEN_W-1:0]  pps_length_reg;
    logic [DATA_W-1:0] read_data_reg;
    logic [DATA_W-1:0] read_data_next;
    logic              advance;

    assign advance  = !out_valid_reg || !out_stall;
    assign in_stall = p1_valid_reg && !advance;

    always_comb
    begin
        case (p1_reg.bank)
            BANK_A:  read_data_next = ram_q[0];
            BANK_B:  read_data_next = ram_q[1];
            BANK_C:  read_data_next = ram_q[2];
            default: read_data_next = '0;
        endcase
        if (!p1_reg.in_range)
        begin
            read_data_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_accept)
            begin
                p1_valid_reg <= res_valid;
            end
            else if (advance)
            begin
                p1_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                out_valid_reg <= p1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            p1_reg <= res;
        end
        if (advance && p1_valid_reg)
        begin
            is_summary_reg <= p1_reg.is_summary;
            keyframe_reg   <= p1_reg.keyframe_seen;
            vcl_reg        <= p1_reg.vcl_seen;
            sps_length_reg <= p1_reg.sps_length;
            pps_length_reg <= p1_reg.pps_length;
            read_data_reg  <= read_data_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign is_summary    = is_summary_reg;
    assign keyframe_seen = keyframe_reg;
    assign vcl_seen      = vcl_reg;
    assign sps_length    = sps_length_reg;
    assign pps_length    = pps_length_reg;
    assign read_data     = read_data_reg;

    a_summary_no_data: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && is_summary_reg |-> read_data_reg == '0)
        else $error("summary carries read data");

    a_p1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |=> p1_valid_reg && $stable(p1_reg))
        else $error("held transaction changed while stalled");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> p1_valid_reg && out_valid_reg && out_stall)
        else $error("input stalled without a full pipeline");

endmodule

FILE: rtl/annexb_nal_scanner.sv
// H.264 Annex-B NAL scanner.
// The input channel (in_valid, in_stall) carries one transaction per cycle
// while in_stall is low: either one bitstream byte (mode 0) or a read of
// one stored SPS or PPS byte (mode 1). A bitstream byte with last_byte set
// closes the buffer. The output channel (out_valid, out_stall) returns one
// transaction for each read and one summary for each closed buffer; other
// bytes return nothing. The block sustains one byte per clock while in_stall
// is low. A result passes the parameter-set memory read and the request
// register, then the output register. Stored sets live in three RAMs of
// SET_BYTES depth whose roles (staging, SPS, PPS) rotate on commit, so no
// copy is needed. When the receiver stalls, the output register and the
// request register hold their transactions, and in_stall rises once both
// are full. Reset clears the scan state, the stored lengths and the flags
// at once; no memory clearing pass is needed, and the block accepts input
// right after reset is released.
module annexb_nal_scanner #(
    parameter int SET_BYTES = 64
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic       mode,
    input  logic [7:0] data_byte,
    input  logic       last_byte,
    input  logic       which_set,
    input  logic [5:0] read_index,
    output logic       out_valid,
    input  logic       out_stall,
    output logic       is_summary,
    output logic       keyframe_seen,
    output logic       vcl_seen,
    output logic [6:0] sps_length,
    output logic [6:0] pps_length,
    output logic [7:0] read_data
);

    import anbs_pkg::*;

    localparam int AW = $clog2(SET_BYTES);

    logic            accept;
    logic            res_valid;
    res_t            res;
    logic [2:0]      wr_en;
    logic [AW-1:0]   wr_addr;
    logic [7:0]      wr_data;
    logic [AW-1:0]   rd_addr;
    logic            rd_en;
    logic [2:0][7:0] ram_q;

    assign accept = in_valid && !in_stall;
    assign rd_en  = accept && mode == MODE_READ;

    anbs_scan #(
        .SET_BYTES (SET_BYTES)
    ) u_scan (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .mode       (mode),
        .data_byte  (data_byte),
        .last_byte  (last_byte),
        .which_set  (which_set),
        .read_index (read_index),
        .res_valid  (res_valid),
        .res        (res),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data),
        .rd_addr    (rd_addr)
    );

    for (genvar i = 0; i < BANKS; i++)
    begin : g_bank
        anbs_ram #(
            .WIDTH (DATA_W),
            .DEPTH (SET_BYTES)
        ) u_ram (
            .clk     (clk),
            .wr_en   (wr_en[i]),
            .wr_addr (wr_addr),
            .wr_data (wr_data),
            .rd_en   (rd_en),
            .rd_addr (rd_addr),
            .rd_data (ram_q[i])
        );
    end

    anbs_out u_out (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_accept     (accept),
        .res_valid     (res_valid),
        .res           (res),
        .ram_q         (ram_q),
        .in_stall      (in_stall),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .is_summary    (is_summary),
        .keyframe_seen (keyframe_seen),
        .vcl_seen      (vcl_seen),
        .sps_length    (sps_length),
        .pps_length    (pps_length),
        .read_data     (read_data)
    );

endmodule
